### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lmma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmma_pkg;

  // default sizes of the stores
  localparam int MATRIX_DIM_DEF  = 1024;
  localparam int SECRET_ROWS_DEF = 8;

  // fixed field widths
  localparam int IDX_W = 10;
  localparam int VAL_W = 16;

  // request command codes
  typedef enum logic [1:0] {
    CMD_LOAD_SECRET = 2'd0,
    CMD_LOAD_NOISE  = 2'd1,
    CMD_ACCUM       = 2'd2,
    CMD_READ        = 2'd3
  } lmma_cmd_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic             sec_we;   // write secret entry with wdata
    logic             acc_we;   // write accumulator entry
    logic             acc_sum;  // accumulator write takes the sum, else wdata
    logic             rd_en;    // read both stores
    logic             mul_en;   // register the product
    logic [IDX_W-1:0] sec_addr;
    logic [IDX_W-1:0] acc_addr;
    logic [VAL_W-1:0] wdata;
  } lmma_lane_ctl_t;

endpackage

`default_nettype wire

### rtl/lmma_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// one row k of the secret and accumulator stores with its multiply-add
module lmma_lane
  import lmma_pkg::*;
#(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
  input  wire logic             clk,
  input  wire lmma_lane_ctl_t   ctl,
  output logic      [VAL_W-1:0] rd_data
);

  localparam int AW = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;

  logic [VAL_W-1:0] sec_mem [MATRIX_DIM];
  logic [VAL_W-1:0] acc_mem [MATRIX_DIM];

  logic [VAL_W-1:0]   sec_rd;
  logic [VAL_W-1:0]   acc_rd;
  logic [VAL_W-1:0]   prod;
  logic [2*VAL_W-1:0] prod_full;
  logic [VAL_W-1:0]   sum;

  // secret store, registered read
  always_ff @(posedge clk) begin
    if (ctl.sec_we) begin
      sec_mem[ctl.sec_addr[AW-1:0]] <= ctl.wdata;
    end
    if (ctl.rd_en) begin
      sec_rd <= sec_mem[ctl.sec_addr[AW-1:0]];
    end
  end

  // accumulator store, written by noise loads or the write-back
  always_ff @(posedge clk) begin
    if (ctl.acc_we) begin
      acc_mem[ctl.acc_addr[AW-1:0]] <= ctl.acc_sum ? sum : ctl.wdata;
    end
    if (ctl.rd_en) begin
      acc_rd <= acc_mem[ctl.acc_addr[AW-1:0]];
    end
  end

  // product modulo 2^16, registered before the add
  assign prod_full = (2*VAL_W)'(ctl.wdata) * (2*VAL_W)'(sec_rd);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_full[VAL_W-1:0];
    end
  end

  assign sum     = acc_rd + prod;
  assign rd_data = acc_rd;

endmodule

`default_nettype wire

### rtl/lwe_matrix_mul_add_wrap16_core.sv
`timescale 1ns / 1ps
`default_nettype none

// LWE matrix multiply-add modulo 2^16: A*s+e (mode 0) or s'*A+e' (mode 1).
// Requests: start with command/row/col/value is taken at a clock edge where
// busy is low. Loads of secret or noise entries write in that same edge and
// leave busy low, so one load per cycle unless an accumulate holds busy high.
// An accumulate of one A element reads all SECRET_ROWS lanes at once,
// multiplies in the next cycle and writes back in the one after: busy is high
// in the ST_MUL and ST_WB states of this read / multiply / write-back pass.
// A read request shows result_value with a one-cycle result_valid strobe after
// the lane read register and the result register; a new request may be taken
// in the cycle after the read, so reads run one per cycle while busy is low.
// Out-of-range reads return 0, other out-of-range requests are dropped.
// Configuration: cfg_data sets mode when cfg_valid is high (cfg_ready is
// always high); write it only with no request in flight.
// Reset (rst, synchronous) clears the sequencer and mode; store contents are
// undefined until written and need no clearing pass. The receiver cannot
// stall: each result is present for exactly one cycle.
module lwe_matrix_mul_add_wrap16_core
  import lmma_pkg::*;
#(
  parameter int MATRIX_DIM  = MATRIX_DIM_DEF,
  parameter int SECRET_ROWS = SECRET_ROWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command,
  input  wire logic [IDX_W-1:0] row,
  input  wire logic [IDX_W-1:0] col,
  input  wire logic [VAL_W-1:0] value,
  output logic                  result_valid,
  output logic      [VAL_W-1:0] result_value,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_RESP
  } state_t;

  state_t state;
  logic   mode;

  logic             accept;
  logic             row_in_rows;
  logic             row_in_dim;
  logic             col_in_dim;
  logic             accum_ok;
  logic [IDX_W-1:0] acc_addr_in;
  logic [IDX_W-1:0] sec_addr_in;

  logic [IDX_W-1:0] acc_addr_q;
  logic [IDX_W-1:0] row_q;
  logic [VAL_W-1:0] value_q;
  logic             rd_ok_q;
  logic [VAL_W-1:0] rd_mux;

  lmma_lane_ctl_t   lane_ctl [SECRET_ROWS];
  logic [VAL_W-1:0] lane_rd  [SECRET_ROWS];

  assign busy      = (state == ST_MUL) || (state == ST_WB);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // range checks on the request
  assign row_in_rows = row < IDX_W'(SECRET_ROWS);
  assign row_in_dim  = {1'b0, row} < (IDX_W+1)'(MATRIX_DIM);
  assign col_in_dim  = {1'b0, col} < (IDX_W+1)'(MATRIX_DIM);
  assign accum_ok    = row_in_dim && col_in_dim;

  // mode picks which index of A is the output column
  assign acc_addr_in = ((command == CMD_ACCUM) && !mode) ? row : col;
  assign sec_addr_in = ((command == CMD_ACCUM) && mode) ? row : col;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // lane control
  for (genvar k = 0; k < SECRET_ROWS; k++) begin : g_lane
    logic hit;

    assign hit = accept && row_in_rows && col_in_dim && (row == IDX_W'(k));

    always_comb begin
      lane_ctl[k].sec_we   = hit && (command == CMD_LOAD_SECRET);
      lane_ctl[k].acc_we   = (hit && (command == CMD_LOAD_NOISE)) || (state == ST_WB);
      lane_ctl[k].acc_sum  = (state == ST_WB);
      lane_ctl[k].rd_en    = accept && (((command == CMD_ACCUM) && accum_ok) ||
                                        (command == CMD_READ));
      lane_ctl[k].mul_en   = (state == ST_MUL);
      lane_ctl[k].sec_addr = sec_addr_in;
      lane_ctl[k].acc_addr = (state == ST_WB) ? acc_addr_q : acc_addr_in;
      lane_ctl[k].wdata    = (state == ST_MUL) ? value_q : value;
    end

    lmma_lane #(
      .MATRIX_DIM(MATRIX_DIM)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl[k]),
      .rd_data(lane_rd[k])
    );
  end

  // request fields kept for the later cycles
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_addr_q <= acc_addr_in;
      row_q      <= row;
      value_q    <= value;
      rd_ok_q    <= row_in_rows && col_in_dim;
    end
  end

  // pick the lane of the read row
  always_comb begin
    rd_mux = '0;
    for (int k = 0; k < SECRET_ROWS; k++) begin
      if (row_q == IDX_W'(k)) begin
        rd_mux = lane_rd[k];
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE, ST_RESP: begin
          if (state == ST_RESP) begin
            result_valid <= 1'b1;
            result_value <= rd_ok_q ? rd_mux : '0;
          end
          state <= ST_IDLE;
          if (accept) begin
            if ((command == CMD_ACCUM) && accum_ok) begin
              state <= ST_MUL;
            end else if (command == CMD_READ) begin
              state <= ST_RESP;
            end
          end
        end
        ST_MUL: begin
          state <= ST_WB;
        end
        ST_WB: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lmma_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// port-level checks of the request and result timing
module lmma_checker
  import lmma_pkg::*;
#(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       command,
  input wire logic [IDX_W-1:0] row,
  input wire logic [IDX_W-1:0] col,
  input wire logic             result_valid
);

  logic take;
  logic take_read;
  logic take_accum;

  assign take       = start && !busy;
  assign take_read  = take && (command == CMD_READ);
  assign take_accum = take && (command == CMD_ACCUM) &&
                      ({1'b0, row} < (IDX_W+1)'(MATRIX_DIM)) &&
                      ({1'b0, col} < (IDX_W+1)'(MATRIX_DIM));

  // a read request gives its result through the lane read and result registers
  `ASSERT_CLK(a_read_result, clk, rst, take_read |-> ##2 result_valid, "read result missing")

  // results come only from read requests
  `ASSERT_CLK(a_result_src, clk, rst, result_valid |-> $past(take_read, 2), "result without read")

  // an accumulate holds requests off through the multiply and write-back states
  `ASSERT_CLK(a_accum_busy, clk, rst, take_accum |=> busy ##1 busy ##1 !busy, "accumulate interlock")

  // other requests leave the block ready
  `ASSERT_CLK(a_no_stall, clk, rst, (take && !take_accum) |=> !busy, "unexpected busy")

endmodule

bind lwe_matrix_mul_add_wrap16_core lmma_checker #(
  .MATRIX_DIM(MATRIX_DIM)
) u_lmma_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .row         (row),
  .col         (col),
  .result_valid(result_valid)
);

`default_nettype wire

### verif/lwe_matrix_mul_add_wrap16_core_test.sv
`timescale 1ns / 1ps

module lwe_matrix_mul_add_wrap16_core_test;
  import lmma_pkg::*;

  localparam int SROWS       = SECRET_ROWS_DEF;
  localparam int MDIM        = MATRIX_DIM_DEF;
  localparam int PHASE_ITEMS = 225;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    lmma_cmd_t        cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
    bit               drain;
  } lmma_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       command = CMD_LOAD_SECRET;
  logic [IDX_W-1:0] row = '0;
  logic [IDX_W-1:0] col = '0;
  logic [VAL_W-1:0] value = '0;
  logic             result_valid;
  logic [VAL_W-1:0] result_value;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data = 1'b0;

  lwe_matrix_mul_add_wrap16_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .row          (row),
    .col          (col),
    .value        (value),
    .result_valid (result_valid),
    .result_value (result_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow state of the block, updated as each request is taken
  logic [VAL_W-1:0] sec_shadow [SROWS][MDIM];
  logic [VAL_W-1:0] acc_shadow [SROWS][MDIM];
  bit               mode_shadow = 1'b0;
  logic [VAL_W-1:0] read_expect [$];
  int unsigned      reads_taken = 0;
  int unsigned      results_seen = 0;
  int unsigned      errors = 0;
  int unsigned      cycle_count = 0;

  // request generation state: which entries have been written so far
  lmma_req_t   pending [$];
  lmma_req_t   cur_req;
  bit          sec_ok [SROWS][MDIM];
  bit          acc_ok [SROWS][MDIM];
  bit          gen_mode = 1'b0;
  int unsigned gen_count = 0;
  int unsigned work_cols [$];
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // apply one taken request to the shadow state
  task automatic apply_request(input lmma_req_t rq);
    logic [IDX_W-1:0] acc_c;
    logic [IDX_W-1:0] sec_c;
    case (rq.cmd)
      CMD_LOAD_SECRET: if (rq.row < SROWS) sec_shadow[rq.row][rq.col] = rq.val;
      CMD_LOAD_NOISE:  if (rq.row < SROWS) acc_shadow[rq.row][rq.col] = rq.val;
      CMD_ACCUM: begin
        acc_c = mode_shadow ? rq.col : rq.row;
        sec_c = mode_shadow ? rq.row : rq.col;
        for (int k = 0; k < SROWS; k++)
          acc_shadow[k][acc_c] = acc_shadow[k][acc_c] + rq.val * sec_shadow[k][sec_c];
      end
      default: begin
        if (rq.row < SROWS) read_expect.push_back(acc_shadow[rq.row][rq.col]);
        else read_expect.push_back('0);
        reads_taken++;
      end
    endcase
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // queue a request and track which store entries it writes
  task automatic add_req(input lmma_cmd_t cmd, input int unsigned r, input int unsigned c,
                         input logic [VAL_W-1:0] v, input bit drain);
    lmma_req_t rq;
    rq.cmd   = cmd;
    rq.row   = IDX_W'(r);
    rq.col   = IDX_W'(c);
    rq.val   = v;
    rq.drain = drain;
    if (cmd == CMD_LOAD_SECRET && r < SROWS) sec_ok[r][c] = 1'b1;
    if (cmd == CMD_LOAD_NOISE && r < SROWS) acc_ok[r][c] = 1'b1;
    // loads that the block drops do not count
    if (!((cmd == CMD_LOAD_SECRET || cmd == CMD_LOAD_NOISE) && r >= SROWS)) gen_count++;
    pending.push_back(rq);
  endtask

  // an accumulate may only touch entries that were written
  function automatic bit accum_ok(input int unsigned r, input int unsigned c);
    int unsigned ac;
    int unsigned sc;
    ac = gen_mode ? c : r;
    sc = gen_mode ? r : c;
    for (int k = 0; k < SROWS; k++)
      if (!sec_ok[k][sc] || !acc_ok[k][ac]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_cols(input lmma_cmd_t cmd);
    foreach (work_cols[i])
      for (int k = 0; k < SROWS; k++) add_req(cmd, k, work_cols[i], rand_val(), 1'b0);
  endtask

  // one phase: optionally a new column set or fresh noise loads, then a mixed stream of requests
  task automatic run_phase(input bit first);
    int unsigned target;
    int unsigned pick;
    int unsigned r;
    int unsigned c;
    target = gen_count + PHASE_ITEMS;
    if (first || $urandom_range(0, 2) != 0) begin
      work_cols.delete();
      if (first) work_cols.push_back(0);
      repeat ($urandom_range(2, 5)) work_cols.push_back($urandom_range(0, MDIM - 1));
      load_cols(CMD_LOAD_SECRET);
      load_cols(CMD_LOAD_NOISE);
    end else if ($urandom_range(0, 1) == 0) begin
      // keep the old columns and secrets, restart the sums from fresh noise
      load_cols(CMD_LOAD_NOISE);
    end
    while (gen_count < target) begin
      pick = $urandom_range(0, 99);
      r = work_cols[$urandom_range(0, work_cols.size() - 1)];
      c = work_cols[$urandom_range(0, work_cols.size() - 1)];
      if (pick < 55) begin
        if (accum_ok(r, c))
          add_req(CMD_ACCUM, r, c, rand_val(), $urandom_range(0, 39) == 0);
      end else if (pick < 75) begin
        add_req(CMD_READ, $urandom_range(0, SROWS - 1), c, rand_val(),
                $urandom_range(0, 39) == 0);
      end else if (pick < 82) begin
        add_req(CMD_READ, $urandom_range(SROWS, MDIM - 1), $urandom_range(0, MDIM - 1),
                rand_val(), 1'b0);
      end else if (pick < 88) begin
        add_req($urandom_range(0, 1) ? CMD_LOAD_NOISE : CMD_LOAD_SECRET,
                $urandom_range(SROWS, MDIM - 1), $urandom_range(0, MDIM - 1),
                rand_val(), 1'b0);
      end else if (pick < 94) begin
        add_req(CMD_LOAD_SECRET, $urandom_range(0, SROWS - 1), c, rand_val(), 1'b0);
      end else begin
        add_req(CMD_LOAD_NOISE, $urandom_range(0, SROWS - 1), c, rand_val(), 1'b0);
      end
    end
  endtask

  // wait until no request is queued or in flight, then let an accumulate finish
  task automatic wait_drained();
    @(negedge clk);
    while (!(pending.size() == 0 && !start && !busy && read_expect.size() == 0))
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    mode_shadow = m;
    gen_mode    = m;
  endtask

  // request driver: bursts with random gaps, holds while busy
  always @(posedge clk) begin : drive_proc
    bit go;
    go = 1'b0;
    if (rst) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) apply_request(cur_req);
      if (start && busy) begin
        go = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0 && (!pending[0].drain || reads_taken == results_seen))
      begin
        cur_req = pending.pop_front();
        go      = 1'b1;
        command <= cur_req.cmd;
        row     <= cur_req.row;
        col     <= cur_req.col;
        value   <= cur_req.val;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start <= go;
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_proc
    logic [VAL_W-1:0] want;
    if (!rst && result_valid) begin
      if (read_expect.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: got %h", result_value);
      end else begin
        want = read_expect.pop_front();
        if (result_value !== want) begin
          errors++;
          if (errors <= 10)
            $display("result_value mismatch: expected %h got %h", want, result_value);
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : main_proc
    bit phase_modes [6];
    phase_modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes on the top column, dropped loads, out-of-range reads
    @(negedge clk);
    for (int k = 0; k < SROWS; k++)
      add_req(CMD_LOAD_SECRET, k, MDIM - 1,
              (k == 0) ? '1 : (k == SROWS - 1) ? '0 : rand_val(), 1'b0);
    for (int k = 0; k < SROWS; k++) add_req(CMD_LOAD_NOISE, k, MDIM - 1, '1, 1'b0);
    add_req(CMD_ACCUM, MDIM - 1, MDIM - 1, '1, 1'b0);
    add_req(CMD_READ, 0, MDIM - 1, '0, 1'b0);
    add_req(CMD_READ, SROWS - 1, MDIM - 1, '0, 1'b0);
    add_req(CMD_READ, SROWS, MDIM - 1, '0, 1'b0);
    add_req(CMD_READ, MDIM - 1, 0, '1, 1'b0);
    add_req(CMD_LOAD_SECRET, SROWS, MDIM - 1, '1, 1'b0);
    add_req(CMD_LOAD_NOISE, MDIM - 1, MDIM - 1, '0, 1'b0);
    add_req(CMD_READ, 0, MDIM - 1, '0, 1'b0);
    add_req(CMD_ACCUM, MDIM - 1, MDIM - 1, '0, 1'b0);
    add_req(CMD_READ, SROWS - 1, MDIM - 1, '0, 1'b0);
    wait_drained();

    // random phases, mode written between them
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      @(negedge clk);
      run_phase(p == 0);
      wait_drained();
    end

    if (errors == 0 && read_expect.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lmma_pkg.sv
rtl/lmma_lane.sv
rtl/lwe_matrix_mul_add_wrap16_core.sv
rtl/lmma_checker.sv
verif/lwe_matrix_mul_add_wrap16_core_test.sv
